FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the RTL; all sample on clock and are disabled in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expr holds on every cycle
`define ASSERT_ALWAYS(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// post holds in the same cycle as pre
`define ASSERT_IMPLIES(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error(msg);

// post holds in the cycle after pre
`define ASSERT_NEXT(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

FILE: rtl/core/rrr_pkg.sv
// Shared types and constants of the reorder and reassembly unit.
package rrr_pkg;

   localparam int ID_W        = 16;
   localparam int SIZE_W      = 11;
   localparam int REF_W       = 16;
   localparam int LEN_W       = 16;
   localparam int KIND_W      = 4;
   localparam int REQ_TDATA_W = 48;
   localparam int RSP_TDATA_W = 64;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   // result kinds
   localparam logic [KIND_W-1:0] KIND_WHOLE      = 4'd0;
   localparam logic [KIND_W-1:0] KIND_APPEND     = 4'd1;
   localparam logic [KIND_W-1:0] KIND_COMPLETE   = 4'd2;
   localparam logic [KIND_W-1:0] KIND_DISCARD    = 4'd3;
   localparam logic [KIND_W-1:0] KIND_OVERSIZE   = 4'd4;
   localparam logic [KIND_W-1:0] KIND_BUFFERED   = 4'd5;
   localparam logic [KIND_W-1:0] KIND_DUPLICATE  = 4'd6;
   localparam logic [KIND_W-1:0] KIND_TOO_FAR    = 4'd7;
   localparam logic [KIND_W-1:0] KIND_STORE_FULL = 4'd8;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_STORE_CAP = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_REASM_CAP = 2'd1;

   localparam logic [CSR_DATA_W-1:0] STORE_CAP_RESET = 16'd16384;
   localparam logic [CSR_DATA_W-1:0] REASM_CAP_RESET = 16'd16384;

   typedef struct packed {
      logic capture;   // latch the accepted request
      logic eval;      // classify the latched request, load a result
      logic drain;     // deliver the parked record read at the last eval or drain
   } cmd_type;

   typedef struct packed {
      logic deliver;   // latched request carries the expected id
      logic more;      // another parked record follows this delivery
      logic out_free;  // result register can take a result this cycle
   } status_type;

endpackage

FILE: rtl/core/rrr_ctrl.sv
// Controller: sequences capture, classification and drain of parked records.
module rrr_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  rrr_pkg::status_type st,
   output rrr_pkg::cmd_type    cmd
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_EVAL  = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   assign req_tready  = (state_ff == ST_IDLE);
   assign cmd.capture = (state_ff == ST_IDLE) && req_tvalid;
   assign cmd.eval    = (state_ff == ST_EVAL) && st.out_free;
   assign cmd.drain   = (state_ff == ST_DRAIN) && st.out_free;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_EVAL;
         end
         ST_EVAL: begin
            if (st.out_free) state_in = (st.deliver && st.more) ? ST_DRAIN : ST_IDLE;
         end
         ST_DRAIN: begin
            if (st.out_free) state_in = st.more ? ST_DRAIN : ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: rtl/core/rrr_dp.sv
// Datapath: window state, slot memory, reassembly state and result register.
module rrr_dp #(
   parameter int WINDOW_SLOTS = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  rrr_pkg::cmd_type                     cmd,
   output rrr_pkg::status_type                  st,
   input  logic [rrr_pkg::REQ_TDATA_W-1:0]      req_tdata,
   input  logic                                 req_tuser,
   input  logic                                 req_tlast,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [rrr_pkg::RSP_TDATA_W-1:0]      rsp_tdata,
   output logic [rrr_pkg::KIND_W-1:0]           rsp_tuser,
   output logic                                 rsp_tlast,
   input  logic                                 csr_valid,
   input  logic [rrr_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [rrr_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   localparam int IW = (WINDOW_SLOTS > 1) ? $clog2(WINDOW_SLOTS) : 1;
   localparam int CW = $clog2(WINDOW_SLOTS + 1);
   localparam logic [IW:0]   SLOTS       = (IW+1)'(WINDOW_SLOTS);
   localparam logic [IW-1:0] LAST_IDX    = IW'(WINDOW_SLOTS - 1);
   localparam logic [IW:0]   DRAIN_LIMIT = (IW+1)'(WINDOW_SLOTS - 1);

   typedef struct packed {
      logic                       frag;
      logic                       last;
      logic [rrr_pkg::SIZE_W-1:0] size;
      logic [rrr_pkg::REF_W-1:0]  pref;
      logic [rrr_pkg::ID_W-1:0]   id;
   } slot_type;

   // configuration
   logic [rrr_pkg::CSR_DATA_W-1:0] store_cap_ff;
   logic [rrr_pkg::CSR_DATA_W-1:0] reasm_cap_ff;

   // window and reassembly state
   logic [rrr_pkg::ID_W-1:0]  next_id_ff;
   logic [IW-1:0]             exp_idx_ff;      // next_id_ff mod WINDOW_SLOTS
   logic [WINDOW_SLOTS-1:0]   slot_valid_ff;
   logic [CW-1:0]             buffered_count_ff;
   logic [rrr_pkg::LEN_W-1:0] store_used_ff;
   logic [rrr_pkg::LEN_W-1:0] reasm_len_ff;
   logic                      skipping_ff;
   logic [IW-1:0]             drain_cnt_ff;

   // latched request
   logic [rrr_pkg::ID_W-1:0]   q_id_ff;
   logic                       q_frag_ff;
   logic                       q_last_ff;
   logic [rrr_pkg::SIZE_W-1:0] q_size_ff;
   logic [rrr_pkg::REF_W-1:0]  q_ref_ff;

   // slot memory
   slot_type slot_mem [WINDOW_SLOTS];
   slot_type rd_ff;

   // result register
   logic                       rsp_valid_ff;
   logic [rrr_pkg::KIND_W-1:0] rsp_kind_ff;
   logic [rrr_pkg::ID_W-1:0]   rsp_id_ff;
   logic [rrr_pkg::REF_W-1:0]  rsp_ref_ff;
   logic [rrr_pkg::SIZE_W-1:0] rsp_size_ff;
   logic [rrr_pkg::LEN_W-1:0]  rsp_len_ff;
   logic                       rsp_last_ff;

   // delivery of one in-order record
   logic                       src_frag;
   logic                       src_last;
   logic [rrr_pkg::SIZE_W-1:0] src_size;
   logic [rrr_pkg::LEN_W:0]    reasm_sum;
   logic                       over;
   logic [rrr_pkg::KIND_W-1:0] d_kind;
   logic [rrr_pkg::LEN_W-1:0]  d_len;
   logic [rrr_pkg::LEN_W-1:0]  d_rlen;
   logic                       d_skip;

   // window arithmetic
   logic                       is_deliver;
   logic                       id_wrap;
   logic [IW-1:0]              nidx;
   logic [rrr_pkg::ID_W-1:0]   id_gap;
   logic                       far;
   logic                       wrapped;
   logic [IW:0]                ins_sum;
   logic [IW:0]                ins_sub;
   logic [IW-1:0]              ins_idx;
   logic [rrr_pkg::LEN_W:0]    store_sum;
   logic [rrr_pkg::KIND_W-1:0] n_kind;
   logic                       do_buffer;
   logic [IW:0]                cnt_after;
   logic                       next_valid;
   logic                       more;
   logic [CW-1:0]              count_dec;
   logic                       load;
   logic                       mem_wr;
   slot_type                   mem_wdata;

   always_comb begin
      src_frag = cmd.drain ? rd_ff.frag : q_frag_ff;
      src_last = cmd.drain ? rd_ff.last : q_last_ff;
      src_size = cmd.drain ? rd_ff.size : q_size_ff;
   end

   assign reasm_sum = {1'b0, reasm_len_ff} + (rrr_pkg::LEN_W+1)'(src_size);
   assign over      = skipping_ff || (reasm_sum > {1'b0, reasm_cap_ff});

   always_comb begin
      d_kind = rrr_pkg::KIND_WHOLE;
      d_len  = rrr_pkg::LEN_W'(src_size);
      d_rlen = reasm_len_ff;
      d_skip = skipping_ff;
      if (src_frag) begin
         if (over) begin
            d_skip = !src_last;
            d_rlen = '0;
            d_len  = '0;
            d_kind = src_last ? rrr_pkg::KIND_OVERSIZE : rrr_pkg::KIND_DISCARD;
         end else begin
            d_len  = reasm_sum[rrr_pkg::LEN_W-1:0];
            d_rlen = src_last ? '0 : reasm_sum[rrr_pkg::LEN_W-1:0];
            d_kind = src_last ? rrr_pkg::KIND_COMPLETE : rrr_pkg::KIND_APPEND;
         end
      end
   end

   assign is_deliver = (q_id_ff == next_id_ff);
   assign id_wrap    = (next_id_ff == '1);

   // the slot index restarts with the id when the id wraps
   always_comb begin
      if (id_wrap || exp_idx_ff == LAST_IDX) nidx = '0;
      else                                  nidx = exp_idx_ff + IW'(1);
   end

   // slot index of an id less than a window ahead, without a divider
   assign id_gap  = q_id_ff - next_id_ff;
   assign far     = (id_gap >= rrr_pkg::ID_W'(WINDOW_SLOTS));
   assign wrapped = (q_id_ff < next_id_ff);
   assign ins_sum = {1'b0, exp_idx_ff} + {1'b0, id_gap[IW-1:0]};
   assign ins_sub = ins_sum - SLOTS;

   always_comb begin
      if (wrapped)               ins_idx = q_id_ff[IW-1:0];
      else if (ins_sum >= SLOTS) ins_idx = ins_sub[IW-1:0];
      else                       ins_idx = ins_sum[IW-1:0];
   end

   assign store_sum = {1'b0, store_used_ff} + (rrr_pkg::LEN_W+1)'(q_size_ff);

   always_comb begin
      do_buffer = 1'b0;
      if (id_gap[rrr_pkg::ID_W-1])          n_kind = rrr_pkg::KIND_DUPLICATE;
      else if (far)                         n_kind = rrr_pkg::KIND_TOO_FAR;
      else if (slot_valid_ff[ins_idx])      n_kind = rrr_pkg::KIND_DUPLICATE;
      else if (store_sum > {1'b0, store_cap_ff}) n_kind = rrr_pkg::KIND_STORE_FULL;
      else begin
         n_kind    = rrr_pkg::KIND_BUFFERED;
         do_buffer = 1'b1;
      end
   end

   // a drain clears its own slot, which the next index may hit after an id wrap
   assign cnt_after  = {1'b0, drain_cnt_ff} + (IW+1)'(1);
   assign next_valid = slot_valid_ff[nidx] && !(cmd.drain && nidx == exp_idx_ff);
   assign more       = next_valid && (cmd.drain ? (cnt_after < DRAIN_LIMIT) : 1'b1);
   assign count_dec  = buffered_count_ff - CW'(1);

   assign st.deliver  = is_deliver;
   assign st.more     = more;
   assign st.out_free = !rsp_valid_ff || rsp_tready;

   assign load   = cmd.eval || cmd.drain;
   assign mem_wr = cmd.eval && !is_deliver && do_buffer;

   always_comb begin
      mem_wdata.frag = q_frag_ff;
      mem_wdata.last = q_last_ff;
      mem_wdata.size = q_size_ff;
      mem_wdata.pref = q_ref_ff;
      mem_wdata.id   = q_id_ff;
   end

   always_ff @(posedge clock) begin
      if (mem_wr) slot_mem[ins_idx] <= mem_wdata;
   end

   always_ff @(posedge clock) begin
      if (load) rd_ff <= slot_mem[nidx];
   end

   // request latch and result payload
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         q_id_ff   <= req_tdata[15:0];
         q_size_ff <= req_tdata[26:16];
         q_ref_ff  <= req_tdata[42:27];
         q_frag_ff <= req_tuser;
         q_last_ff <= req_tuser & req_tlast;
      end
      if (cmd.eval) begin
         rsp_id_ff   <= q_id_ff;
         rsp_ref_ff  <= q_ref_ff;
         rsp_size_ff <= q_size_ff;
         if (is_deliver) begin
            rsp_kind_ff <= d_kind;
            rsp_len_ff  <= d_len;
            rsp_last_ff <= !more;
         end else begin
            rsp_kind_ff <= n_kind;
            rsp_len_ff  <= reasm_len_ff;
            rsp_last_ff <= 1'b1;
         end
      end else if (cmd.drain) begin
         rsp_id_ff   <= rd_ff.id;
         rsp_ref_ff  <= rd_ff.pref;
         rsp_size_ff <= rd_ff.size;
         rsp_kind_ff <= d_kind;
         rsp_len_ff  <= d_len;
         rsp_last_ff <= !more;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         store_cap_ff      <= rrr_pkg::STORE_CAP_RESET;
         reasm_cap_ff      <= rrr_pkg::REASM_CAP_RESET;
         next_id_ff        <= '0;
         exp_idx_ff        <= '0;
         slot_valid_ff     <= '0;
         buffered_count_ff <= '0;
         store_used_ff     <= '0;
         reasm_len_ff      <= '0;
         skipping_ff       <= 1'b0;
         drain_cnt_ff      <= '0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         if (csr_valid) begin
            case (csr_index)
               rrr_pkg::CSR_STORE_CAP: store_cap_ff <= csr_wdata;
               rrr_pkg::CSR_REASM_CAP: reasm_cap_ff <= csr_wdata;
               default: ;
            endcase
         end

         if (load)            rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;

         if (cmd.eval) begin
            if (is_deliver) begin
               reasm_len_ff   <= d_rlen;
               skipping_ff    <= d_skip;
               next_id_ff     <= next_id_ff + rrr_pkg::ID_W'(1);
               exp_idx_ff     <= nidx;
               drain_cnt_ff   <= '0;
               if (buffered_count_ff == '0) store_used_ff <= '0;
            end else if (do_buffer) begin
               slot_valid_ff[ins_idx] <= 1'b1;
               store_used_ff          <= store_sum[rrr_pkg::LEN_W-1:0];
               buffered_count_ff      <= buffered_count_ff + CW'(1);
            end
         end else if (cmd.drain) begin
            reasm_len_ff              <= d_rlen;
            skipping_ff               <= d_skip;
            slot_valid_ff[exp_idx_ff] <= 1'b0;
            buffered_count_ff         <= count_dec;
            next_id_ff                <= next_id_ff + rrr_pkg::ID_W'(1);
            exp_idx_ff                <= nidx;
            drain_cnt_ff              <= cnt_after[IW-1:0];
            if (count_dec == '0) store_used_ff <= '0;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {5'b0, rsp_len_ff, rsp_size_ff, rsp_ref_ff, rsp_id_ff};

endmodule

FILE: rtl/core/reliable_reorder_reassembly_unit.sv
// A request is accepted only in IDLE and latched; its first result is registered in EVAL
// once the result register is free. A delivery then drains its parked records from the
// slot memory in DRAIN (one read per cycle while the result register is free).
// A new request is accepted while the last result still waits in the output register.
// Reset is synchronous, active high: window, counters and reassembly state clear at once;
// slot contents are not cleared, only their valid bits, so no clearing pass is needed.
`include "assert_macros.svh"

module reliable_reorder_reassembly_unit #(
   parameter int WINDOW_SLOTS = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // req_tdata: message_id[15:0], record_size[26:16], payload_ref[42:27], zero [47:43]
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [rrr_pkg::REQ_TDATA_W-1:0]      req_tdata,
   input  logic                                 req_tuser,   // is_fragment
   input  logic                                 req_tlast,   // is_last
   // rsp_tdata: out_message_id[15:0], out_payload_ref[31:16], out_record_size[42:32],
   //            message_length[58:43], zero [63:59]
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [rrr_pkg::RSP_TDATA_W-1:0]      rsp_tdata,
   output logic [rrr_pkg::KIND_W-1:0]           rsp_tuser,   // kind
   output logic                                 rsp_tlast,   // last_result
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [rrr_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [rrr_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   rrr_pkg::cmd_type    cmd;
   rrr_pkg::status_type st;

   assign csr_ready = 1'b1;

   rrr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .st         (st),
      .cmd        (cmd)
   );

   rrr_dp #(
      .WINDOW_SLOTS (WINDOW_SLOTS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .st         (st),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   `ASSERT_ALWAYS(a_one_cmd, $onehot0({cmd.capture, cmd.eval, cmd.drain}), "overlapping commands")
   `ASSERT_NEXT(a_result_loaded, cmd.eval || cmd.drain, rsp_tvalid, "result not presented")
   `ASSERT_NEXT(a_busy_after_request, req_tvalid && req_tready, !req_tready, "request overrun")
   `ASSERT_IMPLIES(a_drain_busy, cmd.drain, !req_tready && !cmd.capture, "drain while idle")

endmodule
